// ----- rtl/charge_row_table_match_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the charge row table
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHARGE_ROW_TABLE_MATCH_MACROS_SVH
`define CHARGE_ROW_TABLE_MATCH_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define CRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("charge row table check failed");
// Plain condition that must hold on every clock edge outside reset.
`define CRT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("charge row table invariant failed");
`else
`define CRT_ASSERT(lbl, clk, rst_n, prop)
`define CRT_ALWAYS(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// Charge row table package
// Shared sizes, request and result codes, and the matcher result bundle.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int ROW_LEN_DEF  = 18;
    localparam int MAX_ROWS_DEF = 256;
    localparam int ELEM_W       = 8;
    localparam int CHARGE_W     = 7;
    localparam logic [CHARGE_W-1:0] CHARGE_LIMIT_RST = 7'd127;

    // Matcher pipeline depth in registers.
    localparam int MATCH_LAT = 4;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_e;

    localparam logic [1:0] RES_LOAD  = 2'd0;
    localparam logic [1:0] RES_QUERY = 2'd1;
    localparam logic [1:0] RES_CLEAR = 2'd2;

    typedef struct packed {
        logic vld;
        logic eq_hit;
        logic par_hit;
    } t_match_s;

endpackage

// ----- rtl/crt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/crt_match.sv -----
// ----------------------------------------------------------------------------
// Row matcher
// Pipelined equality and parallelism test of one stored row against the query.
// ----------------------------------------------------------------------------
module crt_match #(
    parameter int ROW_LEN = crt_pkg::ROW_LEN_DEF,
    parameter int IDX_W   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [IDX_W-1:0]                    i_idx,
    input  logic [ROW_LEN*crt_pkg::ELEM_W-1:0]  i_row,
    input  logic [ROW_LEN*crt_pkg::ELEM_W-1:0]  i_query,
    output crt_pkg::t_match_s                   o_res,
    output logic [IDX_W-1:0]                    o_idx
);

    localparam int EW    = crt_pkg::ELEM_W;
    localparam int PW    = 2 * EW;
    localparam int GRP   = 4;
    localparam int NG    = (ROW_LEN + GRP - 1) / GRP;
    localparam int GW    = PW + $clog2(GRP) + 1;
    localparam int SUM_W = PW + $clog2(ROW_LEN) + 1;
    localparam int SQ_W  = 2 * SUM_W;

    logic                  r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic [IDX_W-1:0]      r_idx_a, r_idx_b, r_idx_c, r_idx_d;
    logic                  r_eq_a, r_eq_b, r_eq_c, r_eq_d;
    logic signed [PW-1:0]  r_pab [ROW_LEN];
    logic signed [PW-1:0]  r_paa [ROW_LEN];
    logic signed [PW-1:0]  r_pbb [ROW_LEN];
    logic signed [GW-1:0]  r_gab [NG];
    logic signed [GW-1:0]  r_gaa [NG];
    logic signed [GW-1:0]  r_gbb [NG];
    logic signed [SUM_W-1:0] r_dot, r_aa, r_bb;
    logic signed [SQ_W-1:0]  r_dot2, r_aabb;

    logic                    w_eq;
    logic signed [GW-1:0]    w_gab [NG];
    logic signed [GW-1:0]    w_gaa [NG];
    logic signed [GW-1:0]    w_gbb [NG];
    logic signed [SUM_W-1:0] w_dot, w_aa, w_bb;

    always_comb begin
        w_eq = 1'b1;
        for (int k = 0; k < ROW_LEN; k++) begin
            if (i_row[k*EW +: EW] != i_query[k*EW +: EW]) begin
                w_eq = 1'b0;
            end
        end
    end

    // Group sums of four products keep each adder chain short.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_gab[g] = '0;
            w_gaa[g] = '0;
            w_gbb[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < ROW_LEN) begin
                    w_gab[g] = w_gab[g] + GW'(r_pab[g*GRP+k]);
                    w_gaa[g] = w_gaa[g] + GW'(r_paa[g*GRP+k]);
                    w_gbb[g] = w_gbb[g] + GW'(r_pbb[g*GRP+k]);
                end
            end
        end
    end

    always_comb begin
        w_dot = '0;
        w_aa  = '0;
        w_bb  = '0;
        for (int g = 0; g < NG; g++) begin
            w_dot = w_dot + SUM_W'(r_gab[g]);
            w_aa  = w_aa  + SUM_W'(r_gaa[g]);
            w_bb  = w_bb  + SUM_W'(r_gbb[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROW_LEN; k++) begin
            r_pab[k] <= PW'($signed(i_row[k*EW +: EW]) * $signed(i_query[k*EW +: EW]));
            r_paa[k] <= PW'($signed(i_row[k*EW +: EW]) * $signed(i_row[k*EW +: EW]));
            r_pbb[k] <= PW'($signed(i_query[k*EW +: EW]) * $signed(i_query[k*EW +: EW]));
        end
        for (int g = 0; g < NG; g++) begin
            r_gab[g] <= w_gab[g];
            r_gaa[g] <= w_gaa[g];
            r_gbb[g] <= w_gbb[g];
        end
        r_dot  <= w_dot;
        r_aa   <= w_aa;
        r_bb   <= w_bb;
        r_dot2 <= SQ_W'(r_dot * r_dot);
        r_aabb <= SQ_W'(r_aa * r_bb);
        r_idx_a <= i_idx;
        r_idx_b <= r_idx_a;
        r_idx_c <= r_idx_b;
        r_idx_d <= r_idx_c;
        r_eq_a  <= w_eq;
        r_eq_b  <= r_eq_a;
        r_eq_c  <= r_eq_b;
        r_eq_d  <= r_eq_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
    end

    assign o_res.vld     = r_vld_d;
    assign o_res.eq_hit  = r_eq_d;
    assign o_res.par_hit = (r_dot2 == r_aabb);
    assign o_idx         = r_idx_d;

endmodule

// ----- rtl/charge_row_table_match.sv -----
// ----------------------------------------------------------------------------
// Charge row table with exact and parallel row match
// Stores rows of signed charges and searches them for a query row.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/busy: one element per request, ROW_LEN elements
//   make a row; the type of the last element decides load or query. A clear
//   request empties the table and drops a partial row. Type 3 is ignored.
//   A finished load row is written into the row memory as its last element
//   is taken, and its result appears in the cycle after. A finished query
//   scans the table, one row per cycle through the row memory read port
//   and a four-register matcher; the result strobes in the cycle busy
//   drops. Clear answers in the cycle after its request.
//   The charge limit register is written on its own valid/ready channel,
//   which is always ready; write it only while the block is idle.
//   Results are held for exactly one cycle under o_result_strobe; the
//   receiver cannot stall them. Reset empties the table, clears the row
//   position and sets the charge limit to 127; no clearing pass is needed
//   since only rows below the row count are ever read.
// ----------------------------------------------------------------------------
`include "charge_row_table_match_macros.svh"

module charge_row_table_match #(
    parameter int ROW_LEN  = crt_pkg::ROW_LEN_DEF,
    parameter int MAX_ROWS = crt_pkg::MAX_ROWS_DEF,
    localparam int IDX_W   = $clog2(MAX_ROWS),
    localparam int CNT_W   = $clog2(MAX_ROWS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic signed [crt_pkg::ELEM_W-1:0] i_charge_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [crt_pkg::CHARGE_W-1:0]  i_cfg_data,
    output logic                          o_result_strobe,
    output logic [1:0]                    o_result_kind,
    output logic                          o_row_accepted,
    output logic                          o_table_full,
    output logic [CNT_W-1:0]              o_row_count,
    output logic                          o_exact_found,
    output logic [IDX_W-1:0]              o_exact_index,
    output logic                          o_multiple_found,
    output logic [IDX_W-1:0]              o_multiple_index
);

    localparam int EW    = crt_pkg::ELEM_W;
    localparam int RW    = ROW_LEN * EW;
    localparam int POS_W = $clog2(ROW_LEN);
    localparam int DRN   = crt_pkg::MATCH_LAT;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} t_state_e;

    t_state_e                      r_state;
    logic [crt_pkg::CHARGE_W-1:0]  r_charge_limit;
    logic [CNT_W-1:0]              r_row_count;
    logic [CNT_W-1:0]              r_res_count;
    logic [POS_W-1:0]              r_pos;
    logic                          r_oob;
    logic signed [EW-1:0]          r_row [ROW_LEN];
    logic [IDX_W-1:0]              r_scan_idx;
    logic [$clog2(DRN+1)-1:0]      r_drain;
    logic                          r_iss_vld;
    logic [IDX_W-1:0]              r_iss_idx;
    logic                          r_ex_found, r_mu_found;
    logic [IDX_W-1:0]              r_ex_idx, r_mu_idx;
    logic                          r_strobe;
    logic [1:0]                    r_kind;
    logic                          r_accepted, r_full;

    crt_pkg::t_req_e    w_req;
    logic               w_accept, w_last, w_elem_oob, w_full, w_ok, w_we, w_re;
    logic [EW:0]        w_mag;
    logic [RW-1:0]      w_row_new, w_query, w_rdata;
    crt_pkg::t_match_s  w_mres;
    logic [IDX_W-1:0]   w_midx;

    assign w_req    = crt_pkg::t_req_e'(i_req_type);
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_last   = (r_pos == POS_W'(ROW_LEN - 1));
    assign w_mag    = i_charge_value[EW-1] ? -{i_charge_value[EW-1], i_charge_value}
                                           : {1'b0, i_charge_value};
    assign w_elem_oob = w_mag > (EW+1)'(r_charge_limit);
    assign w_full   = (r_row_count == CNT_W'(MAX_ROWS));
    assign w_ok     = !(r_oob || w_elem_oob) && !w_full;
    assign w_we     = w_accept && (w_req == crt_pkg::REQ_LOAD) && w_last && w_ok;
    assign w_re     = (r_state == S_SCAN);
    assign o_cfg_ready = 1'b1;

    // Row as it stands with the current element merged in.
    always_comb begin
        for (int k = 0; k < ROW_LEN; k++) begin
            w_row_new[k*EW +: EW] = (POS_W'(k) == r_pos) ? i_charge_value : r_row[k];
            w_query[k*EW +: EW]   = r_row[k];
        end
    end

    crt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row_count[IDX_W-1:0]),
        .i_wdata (w_row_new),
        .i_re    (w_re),
        .i_raddr (r_scan_idx),
        .o_rdata (w_rdata)
    );

    crt_match #(
        .ROW_LEN (ROW_LEN),
        .IDX_W   (IDX_W)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_iss_vld),
        .i_idx   (r_iss_idx),
        .i_row   (w_rdata),
        .i_query (w_query),
        .o_res   (w_mres),
        .o_idx   (w_midx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_charge_limit <= crt_pkg::CHARGE_LIMIT_RST;
            r_row_count    <= '0;
            r_pos          <= '0;
            r_oob          <= 1'b0;
            r_iss_vld      <= 1'b0;
            r_strobe       <= 1'b0;
            r_ex_found     <= 1'b0;
            r_mu_found     <= 1'b0;
        end else begin
            r_strobe  <= 1'b0;
            r_iss_vld <= w_re;
            r_iss_idx <= r_scan_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_charge_limit <= i_cfg_data;
            end
            // First hit wins since rows leave the matcher in index order.
            if (w_mres.vld) begin
                if (w_mres.eq_hit && !r_ex_found) begin
                    r_ex_found <= 1'b1;
                    r_ex_idx   <= w_midx;
                end
                if (w_mres.par_hit && !r_mu_found) begin
                    r_mu_found <= 1'b1;
                    r_mu_idx   <= w_midx;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_req)
                            crt_pkg::REQ_CLEAR: begin
                                r_row_count <= '0;
                                r_pos       <= '0;
                                r_oob       <= 1'b0;
                                r_strobe    <= 1'b1;
                                r_kind      <= crt_pkg::RES_CLEAR;
                                r_accepted  <= 1'b0;
                                r_full      <= 1'b0;
                                r_res_count <= '0;
                                r_ex_found  <= 1'b0;
                                r_mu_found  <= 1'b0;
                            end
                            crt_pkg::REQ_LOAD, crt_pkg::REQ_QUERY: begin
                                r_row[r_pos] <= i_charge_value;
                                if (!w_last) begin
                                    r_pos <= r_pos + POS_W'(1);
                                    r_oob <= r_oob || w_elem_oob;
                                end else begin
                                    r_pos <= '0;
                                    r_oob <= 1'b0;
                                    if (w_req == crt_pkg::REQ_LOAD) begin
                                        r_strobe    <= 1'b1;
                                        r_kind      <= crt_pkg::RES_LOAD;
                                        r_accepted  <= w_ok;
                                        r_full      <= w_full;
                                        r_ex_found  <= 1'b0;
                                        r_mu_found  <= 1'b0;
                                        if (w_ok) begin
                                            r_row_count <= r_row_count + CNT_W'(1);
                                            r_res_count <= r_row_count + CNT_W'(1);
                                        end else begin
                                            r_res_count <= r_row_count;
                                        end
                                    end else begin
                                        r_ex_found <= 1'b0;
                                        r_mu_found <= 1'b0;
                                        r_scan_idx <= '0;
                                        r_state    <= (r_row_count == '0) ? S_EMIT : S_SCAN;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (CNT_W'(r_scan_idx) == r_row_count - CNT_W'(1)) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_drain == ($clog2(DRN+1))'(DRN)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_drain <= r_drain + ($clog2(DRN+1))'(1);
                    end
                end
                S_EMIT: begin
                    r_strobe    <= 1'b1;
                    r_kind      <= crt_pkg::RES_QUERY;
                    r_accepted  <= 1'b0;
                    r_full      <= 1'b0;
                    r_res_count <= r_row_count;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe  = r_strobe;
    assign o_result_kind    = r_kind;
    assign o_row_accepted   = r_accepted;
    assign o_table_full     = r_full;
    assign o_row_count      = r_res_count;
    assign o_exact_found    = r_ex_found;
    assign o_exact_index    = r_ex_found ? r_ex_idx : '0;
    assign o_multiple_found = r_mu_found;
    assign o_multiple_index = r_mu_found ? r_mu_idx : '0;

    `CRT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_row_count <= CNT_W'(MAX_ROWS))
    `CRT_ASSERT(a_write_idle, i_clk, i_rst_n, w_we |-> (r_state == S_IDLE) && !w_full)
    `CRT_ASSERT(a_scan_in_range, i_clk, i_rst_n, w_re |-> CNT_W'(r_scan_idx) < r_row_count)
    `CRT_ASSERT(a_match_while_busy, i_clk, i_rst_n, w_mres.vld |-> (r_state == S_DRAIN) || (r_state == S_SCAN))

endmodule
